/* src/vn3_pkg.sv */
// vn3_pkg: shared types and hash constants for the 3D value noise unit.
// No dependencies; imported by every module of the unit.
`timescale 1ns / 1ps

package vn3_pkg;

  localparam logic [31:0] MIX_MUL = 32'h045d9f3b;
  localparam logic [31:0] MUL_X   = 32'd374761393;
  localparam logic [31:0] MUL_Y   = 32'd668265263;
  localparam logic [31:0] MUL_Z   = 32'd1274126177;

  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned PIPE_DEPTH  = 8;

  // corner index: bit 0 selects x0/x1, bit 1 y0/y1, bit 2 z0/z1
  typedef logic [NUM_CORNERS-1:0][7:0] corners_t;

  // eased fractions, each 0..256
  typedef struct packed {
    logic [8:0] sx;
    logic [8:0] sy;
    logic [8:0] sz;
  } ease_t;

endpackage

/* src/value_noise_3d_fixed_point_unit.sv */
// value_noise_3d_fixed_point_unit: top level of the 3D value noise pipeline.
// Depends on vn3_pkg, vn3_hash, vn3_ease and vn3_lerp.
//
// Usage:
//   Drive in_coord_x/y/z (signed 24.8 fixed point) and raise start. A point is
//   taken at each rising edge where start is high and busy is low. Each taken
//   point yields one noise byte on out_noise_value, marked by out_valid for a
//   single cycle, once the point has passed the hash and blend stages.
//   Throughput, with busy low, is one point per cycle: the corner hash
//   pipeline (weighted sum, two multiply-xorshift rounds) and the three
//   blend stages are fully pipelined; the eight corners hash in parallel lanes.
//   busy is high only during reset and in the first cycle after it, and then
//   stays low. The receiver cannot hold results off, so nothing stalls: a
//   result not taken in its strobe cycle is gone.
//   Reset (rst_n low, synchronous) drops every transaction in flight; no
//   result appears for a point taken before reset.
`timescale 1ns / 1ps

module value_noise_3d_fixed_point_unit import vn3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  output logic        out_valid,
  output logic [7:0]  out_noise_value
);

  logic                  busy_r;
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  corners_t              corners;
  ease_t                 eased, ease_d1_r, ease_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  // advance the valid bits alongside the datapath stages
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], start & ~busy_r};

  vn3_hash u_hash (
    .clk     (clk),
    .coord_x (in_coord_x),
    .coord_y (in_coord_y),
    .coord_z (in_coord_z),
    .corners (corners)
  );

  vn3_ease u_ease (
    .frac_x (in_coord_x[7:0]),
    .frac_y (in_coord_y[7:0]),
    .frac_z (in_coord_z[7:0]),
    .clk    (clk),
    .eased  (eased)
  );

  // delay the eased fractions through ease_d1_r and ease_d2_r to line up with the corner bytes
  always_ff @(posedge clk) begin
    ease_d1_r <= eased;
    ease_d2_r <= ease_d1_r;
  end

  vn3_lerp u_lerp (
    .clk     (clk),
    .corners (corners),
    .eased   (ease_d2_r),
    .noise   (out_noise_value)
  );

  assign busy      = busy_r;
  assign out_valid = vld_r[PIPE_DEPTH-1];

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 8))
    else $error("result strobe without a transaction taken 8 cycles before");

  a_accept_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("accepted transaction produced no result");

  a_busy_only_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !$past(rst_n, 1) || !$past(rst_n, 2))
    else $error("busy raised outside the reset window");

  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_noise_value))
    else $error("result strobe with unknown noise value");

endmodule

/* src/vn3_hash.sv */
// vn3_hash: five-stage pipeline that hashes the eight lattice corners to bytes.
// Depends on vn3_pkg (multiplier constants, corners_t).
`timescale 1ns / 1ps

module vn3_hash import vn3_pkg::*; (
  input  logic        clk,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  output corners_t    corners
);

  function automatic logic [31:0] xs16(input logic [31:0] v);
    xs16 = v ^ {{16{v[31]}}, v[31:16]};
  endfunction

  logic [31:0] xi, yi, zi;
  logic [31:0] px_r, py_r, pz_r;
  logic [NUM_CORNERS-1:0][31:0] sum_r;
  logic [NUM_CORNERS-1:0][31:0] mix1_r;
  logic [NUM_CORNERS-1:0][23:0] mix2_r;
  corners_t corner_r;

  // integer part of each coordinate, sign extended
  assign xi = {{8{coord_x[31]}}, coord_x[31:8]};
  assign yi = {{8{coord_y[31]}}, coord_y[31:8]};
  assign zi = {{8{coord_z[31]}}, coord_z[31:8]};

  // stage 1: weight the low corner coordinates
  always_ff @(posedge clk) begin
    px_r <= xi * MUL_X;
    py_r <= yi * MUL_Y;
    pz_r <= zi * MUL_Z;
  end

  genvar c;
  generate
    for (c = 0; c < NUM_CORNERS; c++) begin : g_corner
      // the +1 corner adds the multiplier once more
      localparam logic [31:0] OFS = (((c % 2) == 1) ? MUL_X : 32'd0)
                                  + ((((c / 2) % 2) == 1) ? MUL_Y : 32'd0)
                                  + ((((c / 4) % 2) == 1) ? MUL_Z : 32'd0);
      logic [31:0] mix1_nxt;
      logic [31:0] mix2_src;
      logic [23:0] mix2_nxt;

      assign mix1_nxt = xs16(sum_r[c]) * MIX_MUL;
      assign mix2_src = xs16(mix1_r[c]);
      // only the low 24 bits feed the final byte
      assign mix2_nxt = mix2_src[23:0] * MIX_MUL[23:0];

      always_ff @(posedge clk) begin
        sum_r[c]    <= px_r + py_r + pz_r + OFS;
        mix1_r[c]   <= mix1_nxt;
        mix2_r[c]   <= mix2_nxt;
        corner_r[c] <= mix2_r[c][7:0] ^ mix2_r[c][23:16];
      end
    end
  endgenerate

  assign corners = corner_r;

endmodule

/* src/vn3_ease.sv */
// vn3_ease: three-stage cubic smoothstep of the three fractional bytes.
// Depends on vn3_pkg (ease_t).
`timescale 1ns / 1ps

module vn3_ease import vn3_pkg::*; (
  input  logic [7:0] frac_x,
  input  logic [7:0] frac_y,
  input  logic [7:0] frac_z,
  input  logic       clk,
  output ease_t      eased
);

  logic [2:0][7:0] t_in;
  logic [2:0][7:0] t_r, t2_r, t2b_r, t3_r;
  logic [2:0][8:0] s_r;

  assign t_in = {frac_z, frac_y, frac_x};

  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      logic [15:0] sq_nxt;
      logic [15:0] cu_nxt;
      logic [9:0]  s_nxt;

      assign sq_nxt = t_in[a] * t_in[a];
      assign cu_nxt = t2_r[a] * t_r[a];
      // 3*t2 - 2*t3 stays within 0..256
      assign s_nxt  = {2'b00, t2b_r[a]} + {1'b0, t2b_r[a], 1'b0} - {1'b0, t3_r[a], 1'b0};

      always_ff @(posedge clk) begin
        t_r[a]   <= t_in[a];
        t2_r[a]  <= sq_nxt[15:8];
        t2b_r[a] <= t2_r[a];
        t3_r[a]  <= cu_nxt[15:8];
        s_r[a]   <= s_nxt[8:0];
      end
    end
  endgenerate

  assign eased.sx = s_r[0];
  assign eased.sy = s_r[1];
  assign eased.sz = s_r[2];

endmodule

/* src/vn3_lerp.sv */
// vn3_lerp: three-stage trilinear blend of the corner bytes, x then y then z.
// Depends on vn3_pkg (corners_t, ease_t).
`timescale 1ns / 1ps

module vn3_lerp import vn3_pkg::*; (
  input  logic       clk,
  input  corners_t   corners,
  input  ease_t      eased,
  output logic [7:0] noise
);

  // a + floor((b - a) * s / 256); the true result lies between a and b
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [8:0] s);
    logic signed [8:0]  d;
    logic signed [9:0]  sw;
    logic signed [18:0] p;
    logic signed [18:0] q;
    d     = $signed({1'b0, b}) - $signed({1'b0, a});
    sw    = $signed({1'b0, s});
    p     = d * sw;
    q     = p >>> 8;
    blend = a + q[7:0];
  endfunction

  logic [3:0][7:0] xb_r;
  logic [1:0][7:0] yb_r;
  logic [7:0]      zb_r;
  logic [8:0]      sy_r, sz_r, sz2_r;

  always_ff @(posedge clk) begin
    xb_r[0] <= blend(corners[0], corners[1], eased.sx);
    xb_r[1] <= blend(corners[2], corners[3], eased.sx);
    xb_r[2] <= blend(corners[4], corners[5], eased.sx);
    xb_r[3] <= blend(corners[6], corners[7], eased.sx);
    sy_r    <= eased.sy;
    sz_r    <= eased.sz;
    yb_r[0] <= blend(xb_r[0], xb_r[1], sy_r);
    yb_r[1] <= blend(xb_r[2], xb_r[3], sy_r);
    sz2_r   <= sz_r;
    zb_r    <= blend(yb_r[0], yb_r[1], sz2_r);
  end

  assign noise = zb_r;

endmodule

/* bench/tb_value_noise_3d_fixed_point_unit.sv */
// tb_value_noise_3d_fixed_point_unit: self-checking bench for the 3D value noise unit.
// Depends on value_noise_3d_fixed_point_unit and vn3_pkg; a directed table, then random points
// under several sender idle rates, each noise byte checked against a local bit-exact predictor or a typed-in value.
`timescale 1ns / 1ps

module tb_value_noise_3d_fixed_point_unit;

  localparam logic [31:0] HASH_MIX = 32'h045d9f3b;
  localparam logic [31:0] WEIGHT_X = 32'd374761393;
  localparam logic [31:0] WEIGHT_Y = 32'd668265263;
  localparam logic [31:0] WEIGHT_Z = 32'd1274126177;

  localparam int NUM_PROBES    = 20;
  localparam int POINTS_PER_PHASE = 177;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        known;
    logic [7:0]  level;
  } probe_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_coord_x;
  logic [31:0] in_coord_y;
  logic [31:0] in_coord_z;
  logic        out_valid;
  logic [7:0]  out_noise_value;

  // typed-in expectation that travels with the point being offered
  logic        typed_ok;
  logic [7:0]  typed_level;

  logic [7:0]  noise_due[$];
  logic [7:0]  due_level;
  int          mismatch_count;
  probe_t      probes [0:NUM_PROBES-1];

  value_noise_3d_fixed_point_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] shr_arith(input logic [31:0] v, input int unsigned n);
    logic signed [31:0] sv;
    sv = v;
    return sv >>> n;
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] v);
    logic [31:0] m;
    m = (shr_arith(v, 16) ^ v) * HASH_MIX;
    m = (shr_arith(m, 16) ^ m) * HASH_MIX;
    return shr_arith(m, 16) ^ m;
  endfunction

  function automatic logic [7:0] lattice_byte(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z);
    logic [31:0] h;
    h = x * WEIGHT_X + y * WEIGHT_Y + z * WEIGHT_Z;
    h = scramble(h);
    return h[7:0];
  endfunction

  // cubic smoothstep of the fraction byte, 0..256
  function automatic logic [31:0] smooth(input logic [7:0] t);
    logic [31:0] tt, t2, t3;
    tt = {24'd0, t};
    t2 = (tt * tt) >> 8;
    t3 = (t2 * tt) >> 8;
    return 32'd3 * t2 - 32'd2 * t3;
  endfunction

  // floor shift keeps the result between the two ends on a falling slope
  function automatic logic [31:0] weigh(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] s);
    logic [31:0] d;
    d = b - a;
    return a + shr_arith(d * s, 8);
  endfunction

  function automatic logic [7:0] noise_at(input logic [31:0] fx, input logic [31:0] fy,
                                          input logic [31:0] fz);
    logic [31:0] ix0, iy0, iz0, ix1, iy1, iz1;
    logic [31:0] sx, sy, sz;
    logic [31:0] a0, a1, b0, b1, e0, e1, r;
    logic [7:0]  c [0:7];
    ix0 = shr_arith(fx, 8);
    iy0 = shr_arith(fy, 8);
    iz0 = shr_arith(fz, 8);
    ix1 = ix0 + 32'd1;
    iy1 = iy0 + 32'd1;
    iz1 = iz0 + 32'd1;
    sx = smooth(fx[7:0]);
    sy = smooth(fy[7:0]);
    sz = smooth(fz[7:0]);
    // corner index: bit 0 picks x, bit 1 y, bit 2 z
    for (int k = 0; k < 8; k++) begin
      c[k] = lattice_byte(k[0] ? ix1 : ix0, k[1] ? iy1 : iy0, k[2] ? iz1 : iz0);
    end
    a0 = weigh({24'd0, c[0]}, {24'd0, c[1]}, sx);
    a1 = weigh({24'd0, c[2]}, {24'd0, c[3]}, sx);
    b0 = weigh({24'd0, c[4]}, {24'd0, c[5]}, sx);
    b1 = weigh({24'd0, c[6]}, {24'd0, c[7]}, sx);
    e0 = weigh(a0, a1, sy);
    e1 = weigh(b0, b1, sy);
    r  = weigh(e0, e1, sz);
    return r[7:0];
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 8191) - 32'd4096;        // near the origin, both signs
      1: v = {16'h0000, v[15:0]};
      2: v = {16'hFFFF, v[15:0]};
      3: v = {8'h7F, 16'hFFFF, v[7:0]};                 // top of the range
      4: v = {8'h80, 16'h0000, v[7:0]};                 // bottom of the range
      default: ;
    endcase
    return v;
  endfunction

  task automatic drive_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic known, input logic [7:0] level,
                             input int unsigned idle_pct);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start       <= 1'b1;
    in_coord_x  <= x;
    in_coord_y  <= y;
    in_coord_z  <= z;
    typed_ok    <= known;
    typed_level <= level;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int unsigned idle_pct;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_coord_x  = '0;
    in_coord_y  = '0;
    in_coord_z  = '0;
    typed_ok    = 1'b0;
    typed_level = '0;
    mismatch_count = 0;

    // origin hashes to zero and has no fraction, so its byte is known outright
    probes = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 8'h00},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 8'h00},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 8'h00},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'h00},
      '{32'hFFFF_FF00, 32'h0000_0000, 32'h0000_0100, 1'b0, 8'h00},
      '{32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 1'b0, 8'h00},
      '{32'h0000_0080, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'h00},
      '{32'h0000_0000, 32'h0000_0080, 32'h0000_0000, 1'b0, 8'h00},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0080, 1'b0, 8'h00},
      '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0, 8'h00},
      '{32'hFFFF_FF80, 32'hFFFF_FE40, 32'hFFFF_FFC0, 1'b0, 8'h00},
      '{32'h7FFF_FF80, 32'h8000_00FF, 32'h0001_0000, 1'b0, 8'h00},
      '{32'h8000_0001, 32'h7FFF_FF00, 32'hFFFF_0000, 1'b0, 8'h00},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 8'h00},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 8'h00},
      '{32'h0000_0340, 32'hFFFF_FCC0, 32'h0000_0A7F, 1'b0, 8'h00},
      '{32'h00FF_FFFF, 32'hFF00_0000, 32'h0000_FFFF, 1'b0, 8'h00},
      '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0, 8'h00},
      '{32'hF0F0_F0F0, 32'h0000_00C0, 32'hFFFF_FF40, 1'b0, 8'h00},
      '{32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 1'b0, 8'h00}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[i]) begin
      drive_point(probes[i].x, probes[i].y, probes[i].z, probes[i].known, probes[i].level, 0);
    end

    // phases: no idling, sender idle often, sender idle rarely
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 61 : 9;
      for (int i = 0; i < POINTS_PER_PHASE; i++) begin
        drive_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, 8'h00, idle_pct);
      end
    end
    start <= 1'b0;

    while (noise_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        noise_due.push_back(typed_ok ? typed_level : noise_at(in_coord_x, in_coord_y, in_coord_z));
      end
      if ($isunknown(out_valid)) begin
        mismatch_count++;
        $display("%0t: out_valid unknown, expected 0 or 1, actual %b", $time, out_valid);
      end else if (out_valid) begin
        if (noise_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction, expected none, actual noise %0d",
                   $time, out_noise_value);
        end else begin
          due_level = noise_due.pop_front();
          if (out_noise_value !== due_level) begin
            mismatch_count++;
            $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                     $time, due_level, out_noise_value);
          end
        end
      end
    end
  end

endmodule

/* sim.f */
src/vn3_pkg.sv
src/vn3_hash.sv
src/vn3_ease.sv
src/vn3_lerp.sv
src/value_noise_3d_fixed_point_unit.sv
bench/tb_value_noise_3d_fixed_point_unit.sv
